// ===== hdl/kls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kls_pkg: shared types and constants of the keyframe linear sampler
// Table size, fraction width, item structs and the record that walks the
// row of key cells.
// ----------------------------------------------------------------------------
package kls_pkg;

    localparam int MAX_KEYS    = 64;
    localparam int FRAC_BITS   = 16;
    localparam int SPAN_MIN    = 7;
    localparam int SLOT_W      = $clog2(MAX_KEYS);
    localparam int CNT_W       = $clog2(MAX_KEYS + 1);
    localparam int QCNT_W      = $clog2(FRAC_BITS + 1);
    localparam int KEY_INDEX_W = 6;
    localparam int CFG_W       = 7;
    localparam int PROD_W      = 34 + FRAC_BITS;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_kls_vec;

    typedef struct packed {
        logic [31:0] tstamp;
        t_kls_vec    val;
    } t_kls_key;

    // Search record handed from cell to cell.
    typedef struct packed {
        logic     vld;
        logic     found;
        logic     last_ge;
        t_kls_key prev;
        t_kls_key nxt;
        t_kls_vec last_v;
    } t_kls_walk;

    typedef struct packed {
        logic                   command;
        logic [KEY_INDEX_W-1:0] key_index;
        logic [31:0]            key_time;
        logic signed [31:0]     value_x;
        logic signed [31:0]     value_y;
        logic signed [31:0]     value_z;
        logic [31:0]            query_time;
    } t_kls_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } t_kls_out;

endpackage

// ===== hdl/keyframe_linear_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_linear_sampler: keyframe table with linear interpolation
// Loads keyframes into a row of cells and samples an x, y, z triple at a
// query time.
// ----------------------------------------------------------------------------
// A load item gives no result. In a sample item the search record steps
// through the row of MAX_KEYS key cells one cell per cycle, the fraction
// then comes from a divider that yields one bit per cycle, and the blend
// registers the product, then adds and saturates into the output register.
// One sample is worked on at a time; a finished result waits in the output
// register while the next item is taken. key_count is to be written only
// while idle, by the user; the block itself does not enforce it.
module keyframe_linear_sampler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  kls_pkg::t_kls_in             i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output kls_pkg::t_kls_out            o_out_item,
    input  logic                         i_cfg_we,
    input  logic [kls_pkg::CFG_W-1:0]    i_cfg_data
);
    import kls_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_DIV  = 4'b0100,
        S_SUM  = 4'b1000
    } t_kls_state;

    t_kls_state        r_state;
    logic [CFG_W-1:0]  r_key_count;
    logic [CNT_W-1:0]  r_n;
    logic [31:0]       r_q;
    t_kls_walk         r_head;
    t_kls_key          r_first;
    t_kls_vec          r_a;
    t_kls_vec          r_b;
    logic              r_use_frac;
    logic              r_out_vld;
    t_kls_out          r_out;

    t_kls_walk         w_walk [0:MAX_KEYS];
    logic [MAX_KEYS:0] w_vld;
    t_kls_walk         tail;
    t_kls_walk         head_start;
    t_kls_key          in_key;
    logic              w_acc;
    logic              w_load;
    logic              w_sample;
    logic [31:0]       span;
    logic              use_frac;
    t_kls_vec          sel_a;
    t_kls_vec          sel_b;
    logic              div_start;
    logic              div_done;
    logic [FRAC_BITS-1:0] div_quo;
    logic [FRAC_BITS-1:0] frac;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic              out_free;

    assign w_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_load   = w_acc && (i_in_item.command == CMD_LOAD);
    assign w_sample = w_acc && (i_in_item.command == CMD_SAMPLE);
    assign in_key   = '{tstamp: i_in_item.key_time,
                        val: '{x: i_in_item.value_x, y: i_in_item.value_y,
                               z: i_in_item.value_z}};

    always_comb begin
        head_start     = '0;
        head_start.vld = w_sample;
    end

    assign w_walk[0] = r_head;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEYS; gi++) begin : g_cell
            kls_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (SLOT_W'(gi)),
                .i_we    (w_load && (32'(i_in_item.key_index) == 32'(gi))),
                .i_key   (in_key),
                .i_q     (r_q),
                .i_n     (r_n),
                .i_walk  (w_walk[gi]),
                .o_walk  (w_walk[gi+1])
            );
        end
        for (gi = 0; gi <= MAX_KEYS; gi++) begin : g_vld
            assign w_vld[gi] = w_walk[gi].vld;
        end
    endgenerate

    assign tail = w_walk[MAX_KEYS];

    // Pick the two blend end points once the search record leaves the row.
    always_comb begin
        span     = tail.nxt.tstamp - tail.prev.tstamp;
        use_frac = (tail.nxt.tstamp > tail.prev.tstamp) && (span >= 32'(SPAN_MIN)) &&
                   (r_q >= tail.prev.tstamp);
        if (r_n == '0) begin
            sel_a    = '0;
            sel_b    = '0;
            use_frac = 1'b0;
        end else if (r_n == CNT_W'(1) || r_q <= r_first.tstamp) begin
            sel_a    = r_first.val;
            sel_b    = r_first.val;
            use_frac = 1'b0;
        end else if (tail.last_ge) begin
            sel_a    = tail.last_v;
            sel_b    = tail.last_v;
            use_frac = 1'b0;
        end else begin
            sel_a = tail.prev.val;
            sel_b = tail.nxt.val;
        end
    end

    assign div_start = (r_state == S_WALK) && tail.vld;

    kls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_q - tail.prev.tstamp),
        .i_den   (span),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign frac = r_use_frac ? div_quo : '0;

    kls_lerp u_lerp_x (
        .i_clk  (i_clk),
        .i_load (div_done),
        .i_a    (r_a.x),
        .i_b    (r_b.x),
        .i_frac (frac),
        .o_res  (res_x)
    );

    kls_lerp u_lerp_y (
        .i_clk  (i_clk),
        .i_load (div_done),
        .i_a    (r_a.y),
        .i_b    (r_b.y),
        .i_frac (frac),
        .o_res  (res_y)
    );

    kls_lerp u_lerp_z (
        .i_clk  (i_clk),
        .i_load (div_done),
        .i_a    (r_a.z),
        .i_b    (r_b.z),
        .i_frac (frac),
        .o_res  (res_z)
    );

    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_count <= '0;
            r_head      <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_head <= head_start;
            if (i_cfg_we) begin
                r_key_count <= i_cfg_data;
            end
            if (r_state == S_SUM && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_sample) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (tail.vld) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sample) begin
            r_q <= i_in_item.query_time;
            r_n <= (r_key_count > CFG_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : CNT_W'(r_key_count);
        end
        if (w_load && i_in_item.key_index == '0) begin
            r_first <= in_key;
        end
        if (div_start) begin
            r_a        <= sel_a;
            r_b        <= sel_b;
            r_use_frac <= use_frac;
        end
        if (r_state == S_SUM && out_free) begin
            r_out <= '{out_x: res_x, out_y: res_y, out_z: res_z};
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    a_tail_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail.vld |-> r_state == S_WALK)
        else $error("search record left the row outside the search phase");

    a_one_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld) <= 1)
        else $error("more than one search record in the row");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide phase");

    a_out_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == S_SUM)
        else $error("result item raised without a finished blend");

endmodule

// ===== hdl/kls_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kls_cell: one keyframe slot of the search row
// Stores one key and updates the passing search record with it.
// ----------------------------------------------------------------------------
module kls_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [kls_pkg::SLOT_W-1:0] i_idx,
    input  logic                      i_we,
    input  kls_pkg::t_kls_key         i_key,
    input  logic [31:0]               i_q,
    input  logic [kls_pkg::CNT_W-1:0] i_n,
    input  kls_pkg::t_kls_walk        i_walk,
    output kls_pkg::t_kls_walk        o_walk
);
    import kls_pkg::*;

    t_kls_key  r_key;
    t_kls_walk r_walk;
    t_kls_walk n_walk;
    logic      in_use;
    logic      is_last;

    always_comb begin
        in_use  = CNT_W'(i_idx) < i_n;
        is_last = (CNT_W'(i_idx) + CNT_W'(1)) == i_n;
        n_walk  = i_walk;
        // The first key in use that lies after the query ends the search;
        // every key in use before it becomes the lower neighbor.
        if (in_use && !i_walk.found) begin
            if (r_key.tstamp > i_q) begin
                n_walk.found = 1'b1;
                n_walk.nxt   = r_key;
            end else begin
                n_walk.prev = r_key;
            end
        end
        if (is_last) begin
            n_walk.last_ge = i_q >= r_key.tstamp;
            n_walk.last_v  = r_key.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key <= i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk <= '0;
        end else begin
            r_walk <= n_walk;
        end
    end

    assign o_walk = r_walk;

endmodule

// ===== hdl/kls_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kls_div: restoring divider for the interpolation fraction
// Produces one fraction bit per cycle from a remainder below the divisor.
// ----------------------------------------------------------------------------
module kls_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [31:0]                   i_num,
    input  logic [31:0]                   i_den,
    output logic                          o_done,
    output logic [kls_pkg::FRAC_BITS-1:0] o_quo
);
    import kls_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [31:0]       r_rem;
    logic [31:0]       r_den;
    logic [FRAC_BITS-1:0] r_quo;
    logic [32:0]       rem2;
    logic [32:0]       diff;
    logic              ge;

    always_comb begin
        rem2 = {r_rem, 1'b0};
        ge   = rem2 >= {1'b0, r_den};
        diff = rem2 - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == QCNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= QCNT_W'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - QCNT_W'(1);
                if (r_cnt == QCNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[31:0] : rem2[31:0];
            r_quo <= {r_quo[FRAC_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== hdl/kls_lerp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kls_lerp: one component of the linear blend
// Registers (b - a) * frac, then adds the floored product to a and saturates.
// ----------------------------------------------------------------------------
module kls_lerp (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic signed [31:0]            i_a,
    input  logic signed [31:0]            i_b,
    input  logic [kls_pkg::FRAC_BITS-1:0] i_frac,
    output logic signed [31:0]            o_res
);
    import kls_pkg::*;

    logic signed [32:0]       diff;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [31:0]       r_a;
    logic signed [33:0]       sum;

    always_comb begin
        diff   = $signed({i_b[31], i_b}) - $signed({i_a[31], i_a});
        w_prod = diff * $signed({1'b0, i_frac});
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= w_prod;
            r_a    <= i_a;
        end
    end

    // Dropping the low bits of a two's complement product rounds toward
    // minus infinity, which is the floor the blend needs.
    always_comb begin
        sum = $signed({{2{r_a[31]}}, r_a}) + $signed(r_prod[PROD_W-1:FRAC_BITS]);
        if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
            o_res = sum[31:0];
        end else if (sum[33]) begin
            o_res = 32'sh8000_0000;
        end else begin
            o_res = 32'sh7FFF_FFFF;
        end
    end

endmodule

// ===== dv/kls_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kls_checker: scoreboard for the keyframe linear sampler
// Watches the item, result and key count ports, keeps its own copy of the
// keyframe table, works out the interpolated triple for every sample item and
// compares each result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module kls_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  kls_pkg::t_kls_in              i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  kls_pkg::t_kls_out             i_out_item,
    input  logic                          i_cfg_we,
    input  logic [kls_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_pending,
    output int                            o_failures
);
    import kls_pkg::*;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    logic [31:0]      key_time_tab [MAX_KEYS];
    t_kls_vec         key_val_tab  [MAX_KEYS];
    logic [CFG_W-1:0] keys_in_use;
    t_kls_out         triple_queue [$];
    int               fail_count;

    // a + floor((b - a) * frac / 2^FRAC_BITS), clamped to signed 32 bits.
    function automatic logic [31:0] blend(input logic signed [31:0] a,
                                          input logic signed [31:0] b,
                                          input logic [FRAC_BITS-1:0] frac);
        longint delta;
        longint sum;
        delta = ((longint'(b) - longint'(a)) * longint'(frac)) >>> FRAC_BITS;
        sum   = longint'(a) + delta;
        if (sum > SAT_HI)
            sum = SAT_HI;
        if (sum < SAT_LO)
            sum = SAT_LO;
        return sum[31:0];
    endfunction

    function automatic t_kls_out sample_at(input logic [31:0] q);
        int                   n;
        int                   nxt;
        bit                   found;
        logic [31:0]          span;
        logic [31:0]          diff;
        logic [63:0]          quo;
        logic [FRAC_BITS-1:0] frac;
        t_kls_vec             va;
        t_kls_vec             vb;
        t_kls_out             r;
        n = (keys_in_use > MAX_KEYS) ? MAX_KEYS : int'(keys_in_use);
        if (n == 0) begin
            r = '0;
        end else if (n == 1 || q <= key_time_tab[0]) begin
            r = key_val_tab[0];
        end else if (q >= key_time_tab[n-1]) begin
            r = key_val_tab[n-1];
        end else begin
            // The first key later than the query; the end checks above make it
            // at least key 1.
            nxt   = n - 1;
            found = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!found && key_time_tab[i] > q) begin
                    nxt   = i;
                    found = 1'b1;
                end
            end
            span = key_time_tab[nxt] - key_time_tab[nxt-1];
            frac = '0;
            if (key_time_tab[nxt] > key_time_tab[nxt-1] && span >= SPAN_MIN &&
                q >= key_time_tab[nxt-1]) begin
                diff = q - key_time_tab[nxt-1];
                quo  = ({32'd0, diff} << FRAC_BITS) / {32'd0, span};
                if (quo > ((64'd1 << FRAC_BITS) - 64'd1))
                    frac = '1;
                else
                    frac = quo[FRAC_BITS-1:0];
            end
            va      = key_val_tab[nxt-1];
            vb      = key_val_tab[nxt];
            r.out_x = blend(va.x, vb.x, frac);
            r.out_y = blend(va.y, vb.y, frac);
            r.out_z = blend(va.z, vb.z, frac);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_kls_out want;
        if (!i_rst_n) begin
            keys_in_use = '0;
            fail_count  = 0;
            triple_queue.delete();
            for (int i = 0; i < MAX_KEYS; i++) begin
                key_time_tab[i] = '0;
                key_val_tab[i]  = '0;
            end
        end else begin
            if (i_cfg_we)
                keys_in_use = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (triple_queue.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result with none outstanding, actual %h %h %h",
                             $time, i_out_item.out_x, i_out_item.out_y,
                             i_out_item.out_z);
                end else begin
                    want = triple_queue.pop_front();
                    check_field("out_x", want.out_x, i_out_item.out_x);
                    check_field("out_y", want.out_y, i_out_item.out_y);
                    check_field("out_z", want.out_z, i_out_item.out_z);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.command == CMD_LOAD) begin
                    if (i_in_item.key_index < MAX_KEYS) begin
                        key_time_tab[i_in_item.key_index] = i_in_item.key_time;
                        key_val_tab[i_in_item.key_index]  = {i_in_item.value_x,
                                                             i_in_item.value_y,
                                                             i_in_item.value_z};
                    end
                end else begin
                    triple_queue.push_back(sample_at(i_in_item.query_time));
                end
            end
        end
        o_pending  <= triple_queue.size();
        o_failures <= fail_count;
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the keyframe linear sampler
// Loads keyframe tables of many sizes and shapes, sets the key count while
// the block is idle, and samples at key times, inside intervals and outside
// the table, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import kls_pkg::*;

    localparam int ITEM_TARGET   = 1950;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 1000000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_kls_in          in_item;
    logic             out_valid;
    logic             out_stall;
    t_kls_out         out_item;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;
    int               pending;
    int               failures;

    logic [31:0]      loaded_time [MAX_KEYS];
    int               items_sent  = 0;
    int               cycle_count = 0;
    bit               tx_quiet    = 1'b0;
    bit               rx_quiet    = 1'b0;

    always #5 clk = ~clk;

    keyframe_linear_sampler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    kls_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_failures  (failures)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("keyframe_linear_sampler verification failed");
            $finish;
        end
    end

    function automatic int pick_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // Distance between neighboring keys: equal, too short to divide, short,
    // or wide.
    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return $urandom_range(1, SPAN_MIN - 1);
            2: return $urandom_range(SPAN_MIN, 64);
            default: return $urandom_range(65, 32'h0200_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_query(input int fill);
        int          k;
        logic [31:0] lo;
        logic [31:0] hi;
        if (fill == 0)
            return $urandom;
        k = $urandom_range(0, fill - 1);
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return loaded_time[k];
            3: return loaded_time[k] + 32'd1;
            4: return loaded_time[k] - 32'd1;
            5: return $urandom;
            default: begin
                if (k == fill - 1)
                    return loaded_time[k];
                lo = loaded_time[k];
                hi = loaded_time[k+1];
                if (hi <= lo)
                    return lo;
                return lo + ($urandom % (hi - lo));
            end
        endcase
    endfunction

    task automatic send_item(input t_kls_in item);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_quiet = !tx_quiet;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (item.command == CMD_LOAD)
            loaded_time[item.key_index] = item.key_time;
    endtask

    task automatic send_load(input logic [KEY_INDEX_W-1:0] idx, input logic [31:0] t,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        t_kls_in item;
        item.command    = CMD_LOAD;
        item.key_index  = idx;
        item.key_time   = t;
        item.value_x    = x;
        item.value_y    = y;
        item.value_z    = z;
        item.query_time = $urandom;
        send_item(item);
    endtask

    task automatic send_sample(input logic [31:0] q);
        t_kls_in item;
        item.command    = CMD_SAMPLE;
        item.key_index  = KEY_INDEX_W'($urandom);
        item.key_time   = $urandom;
        item.value_x    = $urandom;
        item.value_y    = $urandom;
        item.value_z    = $urandom;
        item.query_time = q;
        send_item(item);
    endtask

    // Holds the sender off until every outstanding result is back and the
    // block has had time to finish any trailing work.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_key_count(input logic [CFG_W-1:0] count);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= count;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Result side: stall stays up until a result shows, then drops after the
    // drawn wait. In a quiet stretch it stays down.
    initial begin : result_sink
        int hold;
        out_stall <= 1'b1;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                if ($urandom_range(0, 39) == 0)
                    rx_quiet = !rx_quiet;
                if (!rx_quiet)
                    out_stall <= 1'b1;
            end else if (out_valid) begin
                hold = pick_gap(rx_quiet);
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int          n;
        int          fill;
        int          rounds;
        int          slot;
        bit          scrambled;
        logic [31:0] t;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        repeat (3) @(posedge clk);
        rst_n    <= 1'b1;
        @(posedge clk);

        // Empty table gives zero.
        send_sample(32'h0);
        send_sample(32'hFFFF_FFFF);
        // Keys 0 and 1 are only three LSBs apart, so that interval has no fraction.
        send_load(6'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_load(6'd1, 32'h0001_0003, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_load(6'd2, 32'h0002_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_load(6'd3, 32'hFFFF_FF00, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
        send_load(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_key_count(CFG_W'(1));
        send_sample(32'h0);
        send_sample(32'hFFFF_FFFF);
        set_key_count(CFG_W'(4));
        send_sample(32'h0);
        send_sample(32'h0001_0000);
        send_sample(32'h0001_0001);
        send_sample(32'h0001_8000);
        send_sample(32'h0002_0000);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FEFF);
        send_sample(32'hFFFF_FF00);
        send_sample(32'hFFFF_FFFF);

        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 19))
                0: n = 0;
                1: n = 1;
                2: n = 2;
                3: n = MAX_KEYS;
                4: n = $urandom_range(0, 1) ? (2**CFG_W - 1)
                                            : $urandom_range(MAX_KEYS + 1, 2**CFG_W - 1);
                default: n = $urandom_range(3, 12);
            endcase
            fill      = (n > MAX_KEYS) ? MAX_KEYS : n;
            scrambled = ($urandom_range(0, 7) == 0);
            t         = $urandom_range(0, 32'h1000_0000);
            for (int k = 0; k < fill; k++) begin
                if (scrambled)
                    t = $urandom;
                else if (k > 0)
                    t = t + pick_step();
                send_load(KEY_INDEX_W'(k), t, rand_value(), rand_value(), rand_value());
            end
            set_key_count(CFG_W'(n));
            rounds = $urandom_range(10, 40);
            for (int j = 0; j < rounds; j++) begin
                if (j == rounds / 2 && $urandom_range(0, 3) == 0)
                    drain_results();
                if ($urandom_range(0, 6) == 0) begin
                    // Overwrite a slot, in use or not, with arbitrary content.
                    if (fill < MAX_KEYS && $urandom_range(0, 1) == 1)
                        slot = $urandom_range(fill, MAX_KEYS - 1);
                    else
                        slot = $urandom_range(0, MAX_KEYS - 1);
                    send_load(KEY_INDEX_W'(slot), $urandom, rand_value(), rand_value(),
                              rand_value());
                end else begin
                    send_sample(pick_query(fill));
                end
            end
        end

        drain_results();
        if (failures == 0)
            $display("keyframe_linear_sampler verification clean");
        else
            $display("keyframe_linear_sampler verification failed");
        $finish;
    end

endmodule
